### src/zcls_pkg.sv
// zcls_pkg: shared types and constants of the zero-cross load slot switcher
`timescale 1ns / 1ps
package zcls_pkg;

	localparam int MAX_SLOTS   = 8;
	localparam int SLOT_IDX_W  = 3;
	localparam int PIN_W       = 6;
	localparam int LEVEL_W     = 4;
	localparam int COUNT_W     = 4;
	localparam int INDEX_W     = 8;
	localparam int PIN_MAP_W   = MAX_SLOTS * PIN_W;
	localparam int OPCODE_W    = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int PROFILE_W   = 2 * LEVEL_W;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ZERO_CROSS = 2'd0,
		OP_LEVEL      = 2'd1,
		OP_ENABLE     = 2'd2,
		OP_DISABLE    = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIN_MAP     = 2'd0,
		REG_TRIAC_COUNT = 2'd1,
		REG_RELAY_COUNT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		op_t                opcode;
		logic [PIN_W-1:0]   pin;
		logic [LEVEL_W-1:0] attach_level;
		logic [LEVEL_W-1:0] detach_level;
	} item_t;

	typedef struct packed {
		logic [PIN_MAP_W-1:0] pin_map;
		logic [COUNT_W-1:0]   triac_count;
		logic [COUNT_W-1:0]   relay_count;
	} cfg_t;

	typedef struct packed {
		logic [INDEX_W-1:0]                  slot_index;
		logic [MAX_SLOTS-1:0][PROFILE_W-1:0] profile;
		logic [MAX_SLOTS-1:0]                enable_mask;
		logic [MAX_SLOTS-1:0]                relay_latched;
		logic [MAX_SLOTS-1:0]                drive_state;
	} state_t;

endpackage

### src/zcls_if.sv
// zcls_if: valid/ready channel interfaces for items, results and config writes
`timescale 1ns / 1ps
interface zcls_item_if;
	logic                            valid;
	logic                            ready;
	logic [zcls_pkg::OPCODE_W-1:0]   opcode;
	logic [zcls_pkg::PIN_W-1:0]      pin;
	logic [zcls_pkg::LEVEL_W-1:0]    attach_level;
	logic [zcls_pkg::LEVEL_W-1:0]    detach_level;

	modport source (output valid, opcode, pin, attach_level, detach_level, input ready);
	modport sink   (input valid, opcode, pin, attach_level, detach_level, output ready);
endinterface

interface zcls_result_if;
	logic                           valid;
	logic                           ready;
	logic [zcls_pkg::MAX_SLOTS-1:0] load_on;
	logic                           status;

	modport source (output valid, load_on, status, input ready);
	modport sink   (input valid, load_on, status, output ready);
endinterface

interface zcls_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [zcls_pkg::CFG_IDX_W-1:0]  index;
	logic [zcls_pkg::PIN_MAP_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### src/zcls_cfg_regs.sv
// zcls_cfg_regs: configuration register file (pin map, triac and relay counts)
`timescale 1ns / 1ps
module zcls_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	zcls_cfg_if.sink      cfg_wr,
	output zcls_pkg::cfg_t cfg
);
	import zcls_pkg::*;

	cfg_t cfg_q;

	assign cfg_wr.ready = 1'b1;
	assign cfg         = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr.valid) begin
			unique case (reg_idx_t'(cfg_wr.index))
				REG_PIN_MAP:     cfg_q.pin_map     <= cfg_wr.data;
				REG_TRIAC_COUNT: cfg_q.triac_count <= cfg_wr.data[COUNT_W-1:0];
				REG_RELAY_COUNT: cfg_q.relay_count <= cfg_wr.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end
endmodule

### src/zcls_slot_engine.sv
// zcls_slot_engine: next slot state and status for one item
`timescale 1ns / 1ps
module zcls_slot_engine #(
	parameter int NUM_SLOTS  = 8,
	parameter int NUM_LEVELS = 6
) (
	input  zcls_pkg::item_t  item,
	input  zcls_pkg::cfg_t   cfg,
	input  zcls_pkg::state_t cur,
	output zcls_pkg::state_t nxt,
	output logic             status
);
	import zcls_pkg::*;

	logic [COUNT_W-1:0]    n_triac;
	logic [COUNT_W-1:0]    n_relay;
	logic                  found;
	logic [SLOT_IDX_W-1:0] hit;
	logic                  levels_bad;
	logic                  triac_bad;
	logic [INDEX_W-1:0]    idx;
	logic [LEVEL_W-1:0]    att;
	logic [LEVEL_W-1:0]    dis;
	logic                  is_triac;
	logic                  is_relay;
	logic                  triac_on;
	logic                  relay_on;
	logic                  lat;

	assign n_triac = (cfg.triac_count > COUNT_W'(NUM_SLOTS)) ? COUNT_W'(NUM_SLOTS)
	                                                         : cfg.triac_count;
	assign n_relay = (cfg.relay_count > COUNT_W'(NUM_SLOTS)) ? COUNT_W'(NUM_SLOTS)
	                                                         : cfg.relay_count;

	// lowest slot with a matching pin wins
	always_comb begin
		found = 1'b0;
		hit   = '0;
		for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
			if (cfg.pin_map[s*PIN_W +: PIN_W] == item.pin) begin
				found = 1'b1;
				hit   = SLOT_IDX_W'(s);
			end
		end
	end

	assign levels_bad = ({1'b0, item.attach_level} >= (LEVEL_W+1)'(NUM_LEVELS)) ||
	                    ({1'b0, item.detach_level} >= (LEVEL_W+1)'(NUM_LEVELS));
	assign triac_bad  = ({1'b0, hit} < n_triac) && (item.detach_level <= item.attach_level);

	always_comb begin
		nxt      = cur;
		status   = 1'b0;
		idx      = '0;
		att      = '0;
		dis      = '0;
		is_triac = 1'b0;
		is_relay = 1'b0;
		triac_on = 1'b0;
		relay_on = 1'b0;
		lat      = 1'b0;
		unique case (item.opcode)
			OP_ZERO_CROSS, OP_LEVEL: begin
				idx = (item.opcode == OP_ZERO_CROSS) ? '0 : cur.slot_index + 1'b1;
				nxt.slot_index = idx;
				for (int s = 0; s < MAX_SLOTS; s++) begin
					att      = cur.profile[s][PROFILE_W-1:LEVEL_W];
					dis      = cur.profile[s][LEVEL_W-1:0];
					is_triac = (s < NUM_SLOTS) && (COUNT_W'(s) < n_triac);
					is_relay = (s < NUM_SLOTS) &&
					           ((COUNT_W+1)'(s) + {1'b0, n_relay} >= (COUNT_W+1)'(NUM_SLOTS));
					triac_on = cur.enable_mask[s] && (idx >= INDEX_W'(att)) &&
					           (idx <= INDEX_W'(dis));
					lat      = cur.relay_latched[s];
					relay_on = 1'b0;
					// relay: latch at attach while enabled, release at detach once disabled
					if (cur.enable_mask[s]) begin
						if (lat) begin
							relay_on = 1'b1;
						end else if (idx == INDEX_W'(att)) begin
							relay_on = 1'b1;
							lat      = 1'b1;
						end
					end else if (lat) begin
						if (idx != INDEX_W'(dis)) begin
							relay_on = 1'b1;
						end else begin
							lat = 1'b0;
						end
					end
					if (is_relay) begin
						nxt.drive_state[s]   = relay_on;
						nxt.relay_latched[s] = lat;
					end else begin
						nxt.drive_state[s]   = is_triac && triac_on;
					end
				end
			end
			OP_ENABLE: begin
				if (levels_bad || !found || triac_bad) begin
					status = 1'b1;
				end else begin
					nxt.profile[hit]     = {item.attach_level, item.detach_level};
					nxt.enable_mask[hit] = 1'b1;
				end
			end
			OP_DISABLE: begin
				if (!found) begin
					status = 1'b1;
				end else begin
					nxt.enable_mask[hit] = 1'b0;
				end
			end
			default: ;
		endcase
	end
endmodule

### src/zero_cross_load_slot_switcher.sv
// zero_cross_load_slot_switcher: top level, item register, slot state and result register
//
//   channel     dir  handshake      payload
//   item_in     in   valid/ready    opcode, pin, attach_level, detach_level
//   result_out  out  valid/ready    load_on, status
//   cfg_wr      in   valid/ready    index, data (ready always high)
//
// one item per cycle while the result side keeps up; an item moves from the input
// register into the result register when the input register drains
// the slot state updates on the same edge as the result, so the next item sees it
// a waiting result stalls the input only once the input register holds an item too
// arst_n clears config, slot state and all valid flags; no clearing pass
`timescale 1ns / 1ps
module zero_cross_load_slot_switcher #(
	parameter int NUM_SLOTS  = 8,
	parameter int NUM_LEVELS = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	zcls_item_if.sink     item_in,
	zcls_result_if.source result_out,
	zcls_cfg_if.sink      cfg_wr
);
	import zcls_pkg::*;

	// configuration
	cfg_t cfg;

	// input register
	logic  valid_s1;
	item_t item_s1;

	// result register
	logic                 valid_s2;
	logic [MAX_SLOTS-1:0] load_on_s2;
	logic                 status_s2;

	// slot state
	state_t state_q;
	state_t state_nxt;
	logic   status_nxt;

	logic advance;

	zcls_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.cfg    (cfg)
	);

	zcls_slot_engine #(
		.NUM_SLOTS  (NUM_SLOTS),
		.NUM_LEVELS (NUM_LEVELS)
	) u_engine (
		.item   (item_s1),
		.cfg    (cfg),
		.cur    (state_q),
		.nxt    (state_nxt),
		.status (status_nxt)
	);

	// result register free, or being emptied this cycle
	assign advance       = !valid_s2 || result_out.ready;
	assign item_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.ready && item_in.valid) begin
			item_s1 <= '{opcode:       op_t'(item_in.opcode),
			             pin:          item_in.pin,
			             attach_level: item_in.attach_level,
			             detach_level: item_in.detach_level};
		end
	end

	// state and result move together when the input register drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (valid_s1 && advance) begin
			state_q  <= state_nxt;
			valid_s2 <= 1'b1;
		end else if (result_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			load_on_s2 <= state_nxt.drive_state;
			status_s2  <= status_nxt;
		end
	end

	assign result_out.valid   = valid_s2;
	assign result_out.load_on = load_on_s2;
	assign result_out.status  = status_s2;
endmodule

### tb/sv/zero_cross_load_slot_switcher_test.sv
// zero_cross_load_slot_switcher_test: self-checking testbench of the zero-cross load slot switcher
`timescale 1ns / 1ps
module zero_cross_load_slot_switcher_test;
	import zcls_pkg::*;

	localparam int NUM_SLOTS  = 8;
	localparam int NUM_LEVELS = 6;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 185;
	localparam int LONG_HOLD   = 60;
	// index 3 decodes to no register, writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// expected drive state of every slot, mirrored from the accepted item stream
	class slot_drive_predictor;
		typedef struct packed {
			logic [MAX_SLOTS-1:0] load_on;
			logic                 status;
		} drive_result_t;

		logic [PIN_MAP_W-1:0] pin_map;
		logic [COUNT_W-1:0]   triac_n;
		logic [COUNT_W-1:0]   relay_n;
		logic [INDEX_W-1:0]   level_idx;
		logic [PROFILE_W-1:0] profile [MAX_SLOTS];
		logic [MAX_SLOTS-1:0] enabled;
		logic [MAX_SLOTS-1:0] latched;
		logic [MAX_SLOTS-1:0] drive;
		drive_result_t        awaited [$];
		int                   failures;
		int                   reported;

		function new();
			pin_map   = '0;
			triac_n   = '0;
			relay_n   = '0;
			level_idx = '0;
			enabled   = '0;
			latched   = '0;
			drive     = '0;
			failures  = 0;
			reported  = 0;
			foreach (profile[s])
				profile[s] = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PIN_MAP_W-1:0] data);
			if (idx == REG_PIN_MAP)
				pin_map = data;
			else if (idx == REG_TRIAC_COUNT)
				triac_n = data[COUNT_W-1:0];
			else if (idx == REG_RELAY_COUNT)
				relay_n = data[COUNT_W-1:0];
		endfunction

		function int clamped(logic [COUNT_W-1:0] c);
			return (c > NUM_SLOTS) ? NUM_SLOTS : int'(c);
		endfunction

		function int find_slot(logic [PIN_W-1:0] pin);
			for (int s = 0; s < NUM_SLOTS; s++)
				if (pin_map[s*PIN_W +: PIN_W] == pin)
					return s;
			return -1;
		endfunction

		function void run_tick(bit zero_cross);
			int                   nt;
			int                   nr;
			int                   s;
			bit                   on;
			logic [MAX_SLOTS-1:0] nxt;
			logic [LEVEL_W-1:0]   att;
			logic [LEVEL_W-1:0]   det;
			nt = clamped(triac_n);
			nr = clamped(relay_n);
			nxt = '0;
			if (zero_cross)
				level_idx = '0;
			else
				level_idx = level_idx + 1'b1;
			for (int i = 0; i < nt; i++) begin
				att = profile[i][PROFILE_W-1:LEVEL_W];
				det = profile[i][LEVEL_W-1:0];
				if (enabled[i] && level_idx >= att && level_idx <= det)
					nxt[i] = 1'b1;
			end
			// relay slots from the top down; relay rule wins on overlap
			for (int i = 0; i < nr; i++) begin
				s = NUM_SLOTS - 1 - i;
				att = profile[s][PROFILE_W-1:LEVEL_W];
				det = profile[s][LEVEL_W-1:0];
				on = 1'b0;
				if (enabled[s]) begin
					if (latched[s]) begin
						on = 1'b1;
					end else if (level_idx == att) begin
						on = 1'b1;
						latched[s] = 1'b1;
					end
				end else if (latched[s]) begin
					if (level_idx != det)
						on = 1'b1;
					else
						latched[s] = 1'b0;
				end
				nxt[s] = on;
			end
			drive = nxt;
		endfunction

		function void note_item(item_t it);
			int            s;
			logic          status;
			drive_result_t want;
			status = 1'b0;
			case (it.opcode)
				OP_ZERO_CROSS: run_tick(1'b1);
				OP_LEVEL:      run_tick(1'b0);
				OP_ENABLE: begin
					s = find_slot(it.pin);
					if (s < 0 || it.attach_level >= NUM_LEVELS || it.detach_level >= NUM_LEVELS)
						status = 1'b1;
					else if (s < clamped(triac_n) && it.detach_level <= it.attach_level)
						status = 1'b1;
					else begin
						profile[s] = {it.attach_level, it.detach_level};
						enabled[s] = 1'b1;
					end
				end
				OP_DISABLE: begin
					s = find_slot(it.pin);
					if (s < 0)
						status = 1'b1;
					else
						enabled[s] = 1'b0;
				end
			endcase
			want.load_on = drive;
			want.status = status;
			awaited.push_back(want);
		endfunction

		function void check_result(logic [MAX_SLOTS-1:0] load_on, logic status);
			drive_result_t want;
			if (awaited.size() == 0) begin
				failures++;
				if (reported < 10)
					$display("result with nothing expected: load_on %h status %b", load_on, status);
				reported++;
				return;
			end
			want = awaited.pop_front();
			if (want.load_on !== load_on || want.status !== status) begin
				failures++;
				if (reported < 10)
					$display("mismatch: load_on expected %h actual %h, status expected %b actual %b",
						want.load_on, load_on, want.status, status);
				reported++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	zcls_item_if   item_ch ();
	zcls_result_if result_ch ();
	zcls_cfg_if    cfg_ch ();

	zero_cross_load_slot_switcher #(
		.NUM_SLOTS  (NUM_SLOTS),
		.NUM_LEVELS (NUM_LEVELS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_ch),
		.result_out (result_ch),
		.cfg_wr     (cfg_ch)
	);

	slot_drive_predictor board = new();

	// receiver pacing state, shared with the stimulus process through the request count and the steady flag
	bit rx_steady     = 1'b0;
	int hold_requests = 0;
	int holds_served;
	int hold_left;
	int rx_wait;
	int cycle_count   = 0;
	int sent          = 0;

	always #1 clk = ~clk;

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side: check each transfer, then draw the stall before the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_wait = 0;
			hold_left = 0;
			holds_served = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				board.check_result(result_ch.load_on, result_ch.status);
				rx_wait = rx_steady ? 0 : $urandom_range(0, 3);
			end
			// long hold-off asked by the stimulus side, counted down here
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	function automatic item_t make_item(op_t op, logic [PIN_W-1:0] pin,
			logic [LEVEL_W-1:0] att, logic [LEVEL_W-1:0] det);
		item_t it;
		it.opcode = op;
		it.pin = pin;
		it.attach_level = att;
		it.detach_level = det;
		return it;
	endfunction

	// ticks carry random junk in the fields they ignore
	function automatic item_t tick_item(op_t op);
		return make_item(op, PIN_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom));
	endfunction

	// enable or disable, mostly aimed at a configured pin with in-range levels
	function automatic item_t pick_command();
		item_t it;
		int    s;
		it.opcode = ($urandom_range(0, 2) == 0) ? OP_DISABLE : OP_ENABLE;
		s = $urandom_range(0, NUM_SLOTS - 1);
		if ($urandom_range(0, 4) == 0)
			it.pin = PIN_W'($urandom);
		else
			it.pin = board.pin_map[s*PIN_W +: PIN_W];
		if ($urandom_range(0, 4) == 0) begin
			it.attach_level = LEVEL_W'($urandom);
			it.detach_level = LEVEL_W'($urandom);
		end else begin
			it.attach_level = LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
			it.detach_level = LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
		end
		return it;
	endfunction

	// one item transfer; valid stays high afterwards so the next item can follow back to back
	task automatic send_item(item_t it, bit steady);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= it.opcode;
		item_ch.pin <= it.pin;
		item_ch.attach_level <= it.attach_level;
		item_ch.detach_level <= it.detach_level;
		do @(posedge clk); while (!item_ch.ready);
		board.note_item(it);
		sent++;
	endtask

	task automatic stop_items();
		item_ch.valid <= 1'b0;
	endtask

	// every result is out once nothing is awaited; the block has no result-less items
	task automatic wait_drained();
		while (board.awaited.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PIN_MAP_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		board.set_reg(idx, data);
	endtask

	// only called while idle; count writes carry random upper bits that must be ignored
	task automatic load_config(logic [PIN_MAP_W-1:0] pins, logic [COUNT_W-1:0] tc,
			logic [COUNT_W-1:0] rc, bit touch_unused);
		logic [PIN_MAP_W-1:0] d;
		write_reg(REG_PIN_MAP, pins);
		d = PIN_MAP_W'({$urandom, $urandom});
		d[COUNT_W-1:0] = tc;
		write_reg(REG_TRIAC_COUNT, d);
		d = PIN_MAP_W'({$urandom, $urandom});
		d[COUNT_W-1:0] = rc;
		write_reg(REG_RELAY_COUNT, d);
		if (touch_unused)
			write_reg(REG_UNUSED, PIN_MAP_W'({$urandom, $urandom}));
		cfg_ch.valid <= 1'b0;
	endtask

	// zero cross, then a run of level ticks with commands and some noise mixed in
	task automatic run_half_wave(int level_ticks, bit steady);
		send_item(tick_item(OP_ZERO_CROSS), steady);
		for (int k = 0; k < level_ticks; k++) begin
			if ($urandom_range(0, 3) == 0)
				send_item(pick_command(), steady);
			if ($urandom_range(0, 19) == 0)
				send_item(item_t'(16'($urandom)), steady);
			send_item(tick_item(OP_LEVEL), steady);
		end
	endtask

	initial begin
		logic [PIN_MAP_W-1:0] pins;
		logic [COUNT_W-1:0]   tc;
		logic [COUNT_W-1:0]   rc;
		int                   phase_start;
		bit                   paused;

		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.opcode <= OP_ZERO_CROSS;
		item_ch.pin <= '0;
		item_ch.attach_level <= '0;
		item_ch.detach_level <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_PIN_MAP;
		cfg_ch.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: three triacs, three relays (slots 7..5), slot 5 shares its pin with slot 1
		load_config({6'd48, 6'd17, 6'd63, 6'd5, 6'd42, 6'd21, 6'd63, 6'd0}, 4'd3, 4'd3, 1'b0);
		send_item(make_item(OP_DISABLE, 6'd9, 4'd0, 4'd0), 1'b0);   // unknown pin
		send_item(make_item(OP_ENABLE, 6'd9, 4'd1, 4'd2), 1'b0);    // unknown pin
		send_item(make_item(OP_ENABLE, 6'd0, 4'd6, 4'd2), 1'b0);    // attach out of range
		send_item(make_item(OP_ENABLE, 6'd0, 4'd1, 4'd15), 1'b0);   // detach out of range
		send_item(make_item(OP_ENABLE, 6'd0, 4'd3, 4'd3), 1'b0);    // triac needs detach > attach
		send_item(make_item(OP_ENABLE, 6'd0, 4'd1, 4'd4), 1'b0);    // triac slot 0
		send_item(make_item(OP_ENABLE, 6'd63, 4'd0, 4'd5), 1'b0);   // lowest of two matching slots
		send_item(make_item(OP_ENABLE, 6'd48, 4'd2, 4'd4), 1'b0);   // relay slot 7
		send_item(make_item(OP_ENABLE, 6'd17, 4'd5, 4'd0), 1'b0);   // relay, detach below attach
		send_item(make_item(OP_ENABLE, 6'd5, 4'd0, 4'd0), 1'b0);    // unmanaged slot
		send_item(make_item(OP_ZERO_CROSS, 6'd63, 4'd15, 4'd15), 1'b1);
		repeat (6)
			send_item(tick_item(OP_LEVEL), 1'b1);
		// disabled relay keeps driving until the index comes round to its detach level
		send_item(make_item(OP_DISABLE, 6'd48, 4'd15, 4'd0), 1'b0);
		send_item(make_item(OP_ZERO_CROSS, 6'd0, 4'd0, 4'd0), 1'b0);
		repeat (4)
			send_item(tick_item(OP_LEVEL), 1'b0);
		send_item(make_item(OP_DISABLE, 6'd0, 4'd0, 4'd0), 1'b0);
		stop_items();
		wait_drained();

		// random phases, each under its own register setting
		for (int ph = 0; ph < 7; ph++) begin
			for (int s = 0; s < NUM_SLOTS; s++)
				pins[s*PIN_W +: PIN_W] = PIN_W'($urandom_range(0, 63));
			case (ph)
				0: begin tc = 4'd3;  rc = 4'd3; end
				1: begin tc = 4'd0;  rc = 4'd0; pins = '0; end
				2: begin tc = 4'd8;  rc = 4'd0; pins = '1; end
				3: begin tc = 4'd0;  rc = 4'd8; end
				4: begin tc = 4'd15; rc = 4'd15; end   // both clamp, every slot overlaps
				5: begin tc = 4'd6;  rc = 4'd5; end    // partial overlap
				default: begin tc = 4'd4; rc = 4'd4; end
			endcase
			load_config(pins, tc, rc, ph == 5);
			rx_steady = (ph == 3);
			phase_start = sent;
			paused = 1'b0;
			while (sent - phase_start < PHASE_ITEMS) begin
				run_half_wave($urandom_range(2, 9), $urandom_range(0, 3) == 0);
				// sender pauses halfway until the block has drained
				if (!paused && sent - phase_start >= PHASE_ITEMS / 2) begin
					paused = 1'b1;
					stop_items();
					wait_drained();
				end
			end
			if (ph == 6) begin
				// no zero cross for a while: the index wraps past 255
				for (int k = 0; k < 270; k++) begin
					if ($urandom_range(0, 15) == 0)
						send_item(pick_command(), 1'b0);
					send_item(tick_item(OP_LEVEL), 1'b0);
				end
				// receiver holds off while items keep coming, so the input stalls
				hold_requests++;
				for (int k = 0; k < 40; k++)
					send_item(($urandom_range(0, 3) == 0) ? pick_command() : tick_item(OP_LEVEL),
						1'b1);
			end
			stop_items();
			wait_drained();
		end

		repeat (8) @(posedge clk);
		board.failures += board.awaited.size();
		if (board.failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
